[hdl/sfc_pkg.sv]
// Shared types, constants and helper functions for the sphere frustum culler.
package sfc_pkg;

  // Planes tested, in left, right, bottom, top, near, far order.
  localparam int unsigned PlaneCount   = 6;
  localparam int unsigned NumPlanes    = (PlaneCount > 6) ? 6 : PlaneCount;
  localparam int unsigned NumPlaneRegs = 6;
  localparam int unsigned Dims         = 3;

  // Pipeline: seven datapath stages plus the output register.
  localparam int unsigned NumStages = 8;

  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned CfgDataW = 64;

  // Register indexes of the configuration port.
  localparam logic [CfgAddrW-1:0] RegPlaneLeft   = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] RegPlaneRight  = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] RegPlaneBottom = CfgAddrW'(2);
  localparam logic [CfgAddrW-1:0] RegPlaneTop    = CfgAddrW'(3);
  localparam logic [CfgAddrW-1:0] RegPlaneNear   = CfgAddrW'(4);
  localparam logic [CfgAddrW-1:0] RegPlaneFar    = CfgAddrW'(5);
  localparam logic [CfgAddrW-1:0] RegRigCenter   = CfgAddrW'(6);
  localparam logic [CfgAddrW-1:0] RegRigRadius   = CfgAddrW'(7);

  typedef struct packed {
    logic signed [15:0] xaxis_x;
    logic signed [15:0] xaxis_y;
    logic signed [15:0] xaxis_z;
    logic signed [15:0] yaxis_x;
    logic signed [15:0] yaxis_y;
    logic signed [15:0] yaxis_z;
    logic signed [15:0] zaxis_x;
    logic signed [15:0] zaxis_y;
    logic signed [15:0] zaxis_z;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
  } in_item_t;

  typedef struct packed {
    logic visible;
  } out_item_t;

  // Plane register layout: nx in the low bits, d in the top bits.
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } center_t;

  // World-space centre coordinate in units of 2^-16.
  typedef logic signed [32:0] coord_t;
  // Squared lengths in units of 2^-24.
  typedef logic [31:0] sqlen_t;
  // Squared radius times squared scale.
  typedef logic [63:0] rs_t;

  // Stage advance strobes, one per pipeline register stage.
  typedef struct packed {
    logic [NumStages:1] adv;
  } sfc_ctl_t;

  function automatic sqlen_t sq3(logic signed [15:0] a, logic signed [15:0] b,
                                 logic signed [15:0] c);
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic signed [31:0] pc;
    pa = 32'(a) * 32'(a);
    pb = 32'(b) * 32'(b);
    pc = 32'(c) * 32'(c);
    return sqlen_t'(pa) + sqlen_t'(pb) + sqlen_t'(pc);
  endfunction

endpackage

[hdl/sfc_if.sv]
// Handshake channel interfaces for items, results and configuration writes.
interface sfc_in_if;
  logic              valid;
  logic              ready;
  sfc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfc_out_if;
  logic               valid;
  logic               ready;
  sfc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfc_pkg::CfgAddrW-1:0]  addr;
  logic [sfc_pkg::CfgDataW-1:0]  wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

[hdl/sfc_cfg.sv]
// Configuration registers, with the squared plane normal lengths kept alongside.
module sfc_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfc_cfg_if.sink             cfg_i,
  output sfc_pkg::plane_t     plane_o  [sfc_pkg::NumPlaneRegs],
  output sfc_pkg::sqlen_t     n2_o     [sfc_pkg::NumPlaneRegs],
  output sfc_pkg::center_t    center_o,
  output logic [15:0]         radius_o
);

  sfc_pkg::plane_t  plane_q [sfc_pkg::NumPlaneRegs];
  sfc_pkg::sqlen_t  n2_q    [sfc_pkg::NumPlaneRegs];
  sfc_pkg::center_t center_q;
  logic [15:0]      radius_q;
  sfc_pkg::plane_t  wplane;
  sfc_pkg::sqlen_t  wn2;
  logic             wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign wplane      = sfc_pkg::plane_t'(cfg_i.wdata);
  assign wn2         = sfc_pkg::sq3(wplane.nx, wplane.ny, wplane.nz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < sfc_pkg::NumPlaneRegs; p++) begin
        plane_q[p] <= '0;
        n2_q[p]    <= '0;
      end
      center_q <= '0;
      radius_q <= '0;
    end else if (wr) begin
      for (int p = 0; p < sfc_pkg::NumPlaneRegs; p++) begin
        if (cfg_i.addr == sfc_pkg::CfgAddrW'(p)) begin
          plane_q[p] <= wplane;
          n2_q[p]    <= wn2;
        end
      end
      if (cfg_i.addr == sfc_pkg::RegRigCenter) begin
        center_q <= sfc_pkg::center_t'(cfg_i.wdata[47:0]);
      end
      if (cfg_i.addr == sfc_pkg::RegRigRadius) begin
        radius_q <= cfg_i.wdata[15:0];
      end
    end
  end

  assign plane_o  = plane_q;
  assign n2_o     = n2_q;
  assign center_o = center_q;
  assign radius_o = radius_q;

endmodule

[hdl/sfc_xform.sv]
// Stages one to three: world-space centre and squared scaled radius.
module sfc_xform (
  input  logic              clk_i,
  input  sfc_pkg::sfc_ctl_t ctl_i,
  input  sfc_pkg::in_item_t item_i,
  input  sfc_pkg::center_t  center_i,
  input  logic [15:0]       radius_i,
  output sfc_pkg::coord_t   c_o [sfc_pkg::Dims],
  output sfc_pkg::rs_t      rs_o
);

  logic signed [15:0] col [sfc_pkg::Dims][sfc_pkg::Dims];
  logic signed [15:0] off [sfc_pkg::Dims];
  logic signed [15:0] rc  [sfc_pkg::Dims];

  logic signed [31:0] p1_q   [sfc_pkg::Dims][sfc_pkg::Dims];
  logic signed [15:0] off1_q [sfc_pkg::Dims];
  sfc_pkg::sqlen_t    len1_q [sfc_pkg::Dims];
  logic [31:0]        r2_1_q;

  sfc_pkg::coord_t    c2_q   [sfc_pkg::Dims];
  sfc_pkg::sqlen_t    len2_q [sfc_pkg::Dims];
  logic [31:0]        r2_2_q;

  sfc_pkg::coord_t    c3_q   [sfc_pkg::Dims];
  sfc_pkg::rs_t       rs3_q;
  sfc_pkg::sqlen_t    s2max;

  always_comb begin
    col[0] = '{item_i.xaxis_x, item_i.xaxis_y, item_i.xaxis_z};
    col[1] = '{item_i.yaxis_x, item_i.yaxis_y, item_i.yaxis_z};
    col[2] = '{item_i.zaxis_x, item_i.zaxis_y, item_i.zaxis_z};
    off    = '{item_i.offset_x, item_i.offset_y, item_i.offset_z};
    rc     = '{center_i.x, center_i.y, center_i.z};
  end

  // Stage 1: the nine centre products and the axis column lengths.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[1]) begin
      for (int i = 0; i < sfc_pkg::Dims; i++) begin
        for (int j = 0; j < sfc_pkg::Dims; j++) begin
          p1_q[i][j] <= 32'(col[j][i]) * 32'(rc[j]);
        end
        off1_q[i] <= off[i];
        len1_q[i] <= sfc_pkg::sq3(col[i][0], col[i][1], col[i][2]);
      end
      r2_1_q <= 32'(radius_i) * 32'(radius_i);
    end
  end

  // Stage 2: sum the products and add the offset, scaled to 2^-16 units.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[2]) begin
      for (int i = 0; i < sfc_pkg::Dims; i++) begin
        c2_q[i] <= 33'(p1_q[i][0]) + 33'(p1_q[i][1]) + 33'(p1_q[i][2])
                 + (33'(off1_q[i]) <<< 12);
      end
      len2_q <= len1_q;
      r2_2_q <= r2_1_q;
    end
  end

  always_comb begin
    s2max = len2_q[0];
    if (len2_q[1] > s2max) s2max = len2_q[1];
    if (len2_q[2] > s2max) s2max = len2_q[2];
  end

  // Stage 3: squared radius times the largest squared column length.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[3]) begin
      c3_q  <= c2_q;
      rs3_q <= 64'(r2_2_q) * 64'(s2max);
    end
  end

  assign c_o  = c3_q;
  assign rs_o = rs3_q;

endmodule

[hdl/sfc_plane.sv]
// Stages four to seven for one plane: signed offset, squares and the cull compare.
module sfc_plane (
  input  logic              clk_i,
  input  sfc_pkg::sfc_ctl_t ctl_i,
  input  sfc_pkg::plane_t   plane_i,
  input  sfc_pkg::sqlen_t   n2_i,
  input  sfc_pkg::coord_t   c_i [sfc_pkg::Dims],
  input  sfc_pkg::rs_t      rs_i,
  output logic              cull_o
);

  logic signed [15:0] n [sfc_pkg::Dims];
  logic signed [48:0] pn4_q [sfc_pkg::Dims];
  sfc_pkg::rs_t       rs4_q;
  logic signed [51:0] e5_q;
  sfc_pkg::rs_t       rs5_q;
  logic [51:0]        mag;
  logic [51:0]        mm0_q;
  logic [50:0]        mm1_q;
  logic [49:0]        mm2_q;
  logic [63:0]        rp0_q;
  logic [63:0]        rp1_q;
  logic               neg6_q;
  logic [101:0]       lhs7_q;
  logic [95:0]        rhs7_q;
  logic               neg7_q;
  logic               active;

  assign n      = '{plane_i.nx, plane_i.ny, plane_i.nz};
  assign active = |{plane_i.nx, plane_i.ny, plane_i.nz};

  // Stage 4: normal times centre, one product per axis.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[4]) begin
      for (int i = 0; i < sfc_pkg::Dims; i++) begin
        pn4_q[i] <= 49'(n[i]) * 49'(c_i[i]);
      end
      rs4_q <= rs_i;
    end
  end

  // Stage 5: e = n.c + d, in units of 2^-28.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[5]) begin
      e5_q  <= 52'(pn4_q[0]) + 52'(pn4_q[1]) + 52'(pn4_q[2])
             + (52'(plane_i.d) <<< 24);
      rs5_q <= rs4_q;
    end
  end

  // Stage 6: split |e| squared and rs * |n|^2 into narrow partial products.
  assign mag = 52'(0) - 52'(e5_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[6]) begin
      neg6_q <= e5_q[51];
      mm0_q  <= 52'(mag[25:0]) * 52'(mag[25:0]);
      mm1_q  <= 51'(mag[25:0]) * 51'(mag[50:26]);
      mm2_q  <= 50'(mag[50:26]) * 50'(mag[50:26]);
      rp0_q  <= 64'(rs5_q[31:0]) * 64'(n2_i);
      rp1_q  <= 64'(rs5_q[63:32]) * 64'(n2_i);
    end
  end

  // Stage 7: recombine the partial products.
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv[7]) begin
      neg7_q <= neg6_q;
      lhs7_q <= 102'(mm0_q) + (102'(mm1_q) << 27) + (102'(mm2_q) << 52);
      rhs7_q <= 96'(rp0_q) + (96'(rp1_q) << 32);
    end
  end

  // The sphere lies fully outside when e is negative and e^2 exceeds r^2 |n|^2.
  assign cull_o = active & neg7_q & (lhs7_q > 102'(rhs7_q));

endmodule

[hdl/sphere_frustum_cull.sv]
// Top level of the bounding-sphere frustum culler: control, valid chain and result.
//
//  Port    Dir  Payload                          Meaning
//  cfg_i   in   addr, wdata                      register writes, always ready
//  in_i    in   three axis columns and offset    one instance transform per item
//  out_o   out  visible                          one result item per input item
//
// One item enters per cycle, while the output is not stalled, through eight register
// stages: centre products, centre sums, scale product, plane products, plane sums,
// split squares, recombine and the output register. An accepted item passes the
// stages in that order; its result is valid once it reaches the output register.
// Each stage advances when it is empty or when the stage after it advances, so
// bubbles close up under a stall and no item is lost or repeated. Reset clears
// the configuration registers and the valid bits; payload registers carry no reset.
module sphere_frustum_cull (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfc_cfg_if.sink   cfg_i,
  sfc_in_if.sink    in_i,
  sfc_out_if.source out_o
);

  sfc_pkg::plane_t   plane  [sfc_pkg::NumPlaneRegs];
  sfc_pkg::sqlen_t   n2     [sfc_pkg::NumPlaneRegs];
  sfc_pkg::center_t  center;
  logic [15:0]       radius;
  sfc_pkg::coord_t   c      [sfc_pkg::Dims];
  sfc_pkg::rs_t      rs;
  logic [sfc_pkg::NumPlanes-1:0] cull;

  sfc_pkg::sfc_ctl_t ctl;
  logic [sfc_pkg::NumStages+1:1] adv;
  logic [sfc_pkg::NumStages:1]   v_q;
  logic [sfc_pkg::NumStages-1:1] rnz_q;
  logic                          vis_q;

  sfc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_i,
    .plane_o  (plane),
    .n2_o     (n2),
    .center_o (center),
    .radius_o (radius)
  );

  sfc_xform u_xform (
    .clk_i,
    .ctl_i    (ctl),
    .item_i   (in_i.data),
    .center_i (center),
    .radius_i (radius),
    .c_o      (c),
    .rs_o     (rs)
  );

  for (genvar p = 0; p < sfc_pkg::NumPlanes; p++) begin : g_plane
    sfc_plane u_plane (
      .clk_i,
      .ctl_i   (ctl),
      .plane_i (plane[p]),
      .n2_i    (n2[p]),
      .c_i     (c),
      .rs_i    (rs),
      .cull_o  (cull[p])
    );
  end

  // A stage may load when it holds nothing or its contents move on this cycle.
  always_comb begin
    adv[sfc_pkg::NumStages+1] = out_o.ready;
    for (int k = sfc_pkg::NumStages; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    ctl.adv = adv[sfc_pkg::NumStages:1];
  end

  assign in_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= in_i.valid;
      for (int k = 2; k <= sfc_pkg::NumStages; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // A zero radius marks an instance without a rig, which is always visible.
  always_ff @(posedge clk_i) begin
    if (adv[1]) rnz_q[1] <= |radius;
    for (int k = 2; k < sfc_pkg::NumStages; k++) begin
      if (adv[k]) rnz_q[k] <= rnz_q[k-1];
    end
    if (adv[sfc_pkg::NumStages]) begin
      vis_q <= !rnz_q[sfc_pkg::NumStages-1] || !(|cull);
    end
  end

  assign out_o.valid        = v_q[sfc_pkg::NumStages];
  assign out_o.data.visible = vis_q;

  a_no_rig_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv[sfc_pkg::NumStages] && v_q[sfc_pkg::NumStages-1]
     && !rnz_q[sfc_pkg::NumStages-1]) |=> out_o.data.visible)
    else $error("item without a rig was reported culled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v_q[1])
    else $error("accepted item did not enter the first stage");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[sfc_pkg::NumStages] |-> in_i.ready)
    else $error("input stalled while the output stage is empty");

endmodule

[tb/sfc_scoreboard.sv]
// Scoreboard class: predicts the visible flag for each instance and checks results.
package sfc_scoreboard_pkg;

  class cull_scoreboard;
    logic [63:0] plane_word[sfc_pkg::NumPlaneRegs];
    logic [47:0] center_word;
    logic [15:0] radius_word;
    bit          visible_q[$];
    int unsigned fail_count;

    function void write_reg(logic [sfc_pkg::CfgAddrW-1:0] idx, logic [63:0] val);
      if (idx <= sfc_pkg::RegPlaneFar) begin
        plane_word[idx] = val;
      end else if (idx == sfc_pkg::RegRigCenter) begin
        center_word = val[47:0];
      end else if (idx == sfc_pkg::RegRigRadius) begin
        radius_word = val[15:0];
      end
    endfunction

    function void clear();
      foreach (plane_word[i]) plane_word[i] = '0;
      center_word = '0;
      radius_word = '0;
      fail_count  = 0;
    endfunction

    // Exact sphere-against-planes test on wide integers.
    function bit predict_visible(sfc_pkg::in_item_t it);
      longint ax[3], ay[3], az[3], off[3], rc[3], cw[3];
      logic [127:0] e2, rhs, rs, s2, t, n2;
      longint nx, ny, nz, dd, e;
      sfc_pkg::plane_t pl;
      ax = '{it.xaxis_x, it.xaxis_y, it.xaxis_z};
      ay = '{it.yaxis_x, it.yaxis_y, it.yaxis_z};
      az = '{it.zaxis_x, it.zaxis_y, it.zaxis_z};
      off = '{it.offset_x, it.offset_y, it.offset_z};
      for (int k = 0; k < 3; k++) begin
        rc[k] = longint'($signed(center_word[16*k +: 16]));
      end
      if (radius_word == 0) return 1'b1;
      for (int k = 0; k < 3; k++) begin
        cw[k] = ax[k] * rc[0] + ay[k] * rc[1] + az[k] * rc[2] + off[k] * 4096;
      end
      s2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
      t  = ay[0] * ay[0] + ay[1] * ay[1] + ay[2] * ay[2];
      if (t > s2) s2 = t;
      t  = az[0] * az[0] + az[1] * az[1] + az[2] * az[2];
      if (t > s2) s2 = t;
      rs = 128'(radius_word) * 128'(radius_word) * s2;
      for (int p = 0; p < sfc_pkg::NumPlanes; p++) begin
        pl = plane_word[p];
        nx = pl.nx;
        ny = pl.ny;
        nz = pl.nz;
        dd = pl.d;
        if (nx == 0 && ny == 0 && nz == 0) continue;
        e = nx * cw[0] + ny * cw[1] + nz * cw[2] + dd * 16777216;
        if (e >= 0) continue;
        e2  = 128'(-e) * 128'(-e);
        n2  = nx * nx + ny * ny + nz * nz;
        rhs = rs * n2;
        if (e2 > rhs) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(sfc_pkg::in_item_t it);
      visible_q = {visible_q, predict_visible(it)};
    endfunction

    function void check_result(sfc_pkg::out_item_t res);
      bit want;
      if (visible_q.size() == 0) begin
        $error("unexpected result item, visible=%0b", res.visible);
        fail_count++;
        return;
      end
      want = visible_q.pop_front();
      if (res.visible !== want) begin
        $error("field visible: expected %0b actual %0b", want, res.visible);
        fail_count++;
      end
    endfunction
  endclass
endpackage

[tb/sphere_frustum_cull_test.sv]
// Testbench top: drives instance transforms and register writes, checks visibility.
module sphere_frustum_cull_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  sfc_cfg_if cfg_ch();
  sfc_in_if  in_ch();
  sfc_out_if out_ch();

  sphere_frustum_cull u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  sfc_scoreboard_pkg::cull_scoreboard cull_sb;
  int unsigned    cycle_count = 0;
  bit             sink_stalls = 1'b1;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.addr  = '0;
    cfg_ch.wdata = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Gap lengths are mostly zero or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Timeout watchdog; it also counts cycles for the limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: the ready line drops at random while sink_stalls is set, and each accepted item is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) cull_sb.check_result(out_ch.data);
      if (!sink_stalls) out_ch.ready <= 1'b1;
      else out_ch.ready <= (pick_gap() == 0) || ($urandom_range(3) == 0);
    end
  end

  // One register write, after which the configuration port is left idle before the task returns.
  task automatic write_reg(logic [sfc_pkg::CfgAddrW-1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cull_sb.write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the item until it is accepted, then, if with_gaps is set, idles for a random gap.
  task automatic send_item(sfc_pkg::in_item_t it, bit with_gaps);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    cull_sb.note_input(it);
    gap = with_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cull_sb.visible_q.size() != 0) @(posedge clk_i);
    repeat (sfc_pkg::NumStages + 4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] make_plane(logic [15:0] nx, logic [15:0] ny,
                                             logic [15:0] nz, logic [15:0] d);
    return {d, nz, ny, nx};
  endfunction

  // Identity rotation (1.0 in Q4.12) and the given translation.
  function automatic sfc_pkg::in_item_t identity_at(logic [15:0] ox, logic [15:0] oy,
                                                    logic [15:0] oz);
    sfc_pkg::in_item_t it;
    it = '0;
    it.xaxis_x  = 16'sd4096;
    it.yaxis_y  = 16'sd4096;
    it.zaxis_z  = 16'sd4096;
    it.offset_x = ox;
    it.offset_y = oy;
    it.offset_z = oz;
    return it;
  endfunction

  // Random item: mostly plausible transforms near the frustum, some full range.
  function automatic sfc_pkg::in_item_t random_item();
    sfc_pkg::in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      it.xaxis_x  = $signed(16'($urandom_range(8192))) - 16'sd4096;
      it.xaxis_y  = $signed(16'($urandom_range(8192))) - 16'sd4096;
      it.yaxis_y  = $signed(16'($urandom_range(8192))) - 16'sd4096;
      it.zaxis_z  = $signed(16'($urandom_range(8192))) - 16'sd4096;
      it.xaxis_z  = $signed(16'($urandom_range(2048))) - 16'sd1024;
      it.offset_x = $signed(16'($urandom_range(4096))) - 16'sd2048;
      it.offset_y = $signed(16'($urandom_range(4096))) - 16'sd2048;
      it.offset_z = $signed(16'($urandom_range(4096))) - 16'sd2048;
    end
    return it;
  endfunction

  // A box frustum of half-width w (Q12.4) on each axis, normals of unit length.
  task automatic load_box(logic [15:0] w);
    write_reg(sfc_pkg::RegPlaneLeft,   make_plane(16'sd4096, 16'd0, 16'd0, w));
    write_reg(sfc_pkg::RegPlaneRight,  make_plane(-16'sd4096, 16'd0, 16'd0, w));
    write_reg(sfc_pkg::RegPlaneBottom, make_plane(16'd0, 16'sd4096, 16'd0, w));
    write_reg(sfc_pkg::RegPlaneTop,    make_plane(16'd0, -16'sd4096, 16'd0, w));
    write_reg(sfc_pkg::RegPlaneNear,   make_plane(16'd0, 16'd0, 16'sd4096, w));
    write_reg(sfc_pkg::RegPlaneFar,    make_plane(16'd0, 16'd0, -16'sd4096, w));
  endtask

  initial begin
    sfc_pkg::in_item_t it;
    logic [sfc_pkg::CfgAddrW-1:0] reg_idx;
    cull_sb = new();
    cull_sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With a zero radius every instance must be visible.
    load_box(16'sd160);
    send_item(identity_at(16'sh7fff, 16'sh7fff, 16'sh7fff), 1'b0);
    drain();

    write_reg(sfc_pkg::RegRigCenter, 64'd0);
    write_reg(sfc_pkg::RegRigRadius, 64'd16);
    // Sphere of radius one against a box of half-width ten: inside, touching, outside.
    send_item(identity_at(16'd0, 16'd0, 16'd0), 1'b0);
    send_item(identity_at(16'sd176, 16'd0, 16'd0), 1'b0);
    send_item(identity_at(16'sd177, 16'd0, 16'd0), 1'b0);
    send_item(identity_at(16'd0, -16'sd177, 16'd0), 1'b0);
    send_item(identity_at(16'd0, 16'd0, 16'sh8000), 1'b0);
    send_item(identity_at(16'sh7fff, 16'sh7fff, 16'sh7fff), 1'b0);
    // Collapsed transform gives radius zero; only the centre is tested.
    it = '0;
    send_item(it, 1'b0);
    it.offset_x = 16'sd161;
    send_item(it, 1'b0);
    // Extreme axis entries and offsets.
    it = {12{16'sh8000}};
    send_item(it, 1'b0);
    it = {12{16'sh7fff}};
    send_item(it, 1'b0);
    it = '1;
    send_item(it, 1'b0);
    drain();

    // Zero-normal planes are skipped even with a culling offset.
    for (int p = 0; p < sfc_pkg::NumPlaneRegs; p++) begin
      write_reg(sfc_pkg::CfgAddrW'(p), make_plane(16'd0, 16'd0, 16'd0, 16'sh8000));
    end
    write_reg(sfc_pkg::RegRigCenter, {16'h0000, 16'sh7fff, 16'sh8000, 16'sh7fff});
    write_reg(sfc_pkg::RegRigRadius, 64'hffff);
    send_item(identity_at(16'sh8000, 16'd0, 16'sh7fff), 1'b0);
    drain();
    // Extreme plane words, including the largest normal and offset values.
    write_reg(sfc_pkg::RegPlaneLeft, {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    write_reg(sfc_pkg::RegPlaneRight, {16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_item(identity_at(16'sh8000, 16'sh8000, 16'sh8000), 1'b0);
    send_item(identity_at(16'sh7fff, 16'sh7fff, 16'sh7fff), 1'b0);
    drain();

    // Writes to indexes past the last register must change nothing.
    write_reg(sfc_pkg::CfgAddrW'(8), '1);
    write_reg(sfc_pkg::CfgAddrW'(255), '1);

    // Random phases, each with a fresh setting of the registers.
    for (int phase = 0; phase < 20; phase++) begin
      sink_stalls = (phase % 4) != 3;
      if (phase % 3 == 0) begin
        load_box(16'($urandom_range(2000, 16)));
      end else begin
        for (int p = 0; p < sfc_pkg::NumPlaneRegs; p++) begin
          // Some planes get a zero normal, some a random word.
          write_reg(sfc_pkg::CfgAddrW'(p), ($urandom_range(5) == 0) ?
                    {16'($urandom), 48'd0} : {$urandom, $urandom});
        end
      end
      write_reg(sfc_pkg::RegRigCenter, ($urandom_range(2) == 0) ? {$urandom, $urandom} :
                {16'h0000,
                 16'($signed(16'($urandom_range(64))) - 16'sd32),
                 16'($signed(16'($urandom_range(64))) - 16'sd32),
                 16'($signed(16'($urandom_range(64))) - 16'sd32)});
      case ($urandom_range(5))
        0: write_reg(sfc_pkg::RegRigRadius, 64'd0);
        1: write_reg(sfc_pkg::RegRigRadius, 64'hffff);
        2: write_reg(sfc_pkg::RegRigRadius, {$urandom, $urandom});
        default: write_reg(sfc_pkg::RegRigRadius, 64'($urandom_range(800, 1)));
      endcase
      if ($urandom_range(4) == 0) begin
        reg_idx = sfc_pkg::CfgAddrW'($urandom_range(255, 8));
        write_reg(reg_idx, {$urandom, $urandom});
      end
      for (int n = 0; n < 100; n++) begin
        send_item(random_item(), phase % 5 != 4);
      end
      drain();
    end

    if (cull_sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
